@@ rtl/qpht_pkg.sv @@
// qpht_pkg: shared types, constants and codes of the quadratic probe hash table
package qpht_pkg;

	localparam int TABLE_SIZE = 256;
	localparam int KEY_BYTES  = 8;

	localparam int KEY_W  = 64;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;
	localparam int SLOT_W = 8;
	localparam int HASH_W = 32;
	localparam int MARK_W = 2;
	localparam int IDX_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int PW     = IDX_W + 1;
	localparam int CNT_W  = 3;
	localparam int LEN_W  = 4;
	localparam int NIB_N  = HASH_W / 4;
	localparam int NIB_CW = $clog2(NIB_N);

	// 2^32 mod table size, used when the probe sum wraps
	localparam longint unsigned WORD_SPAN = 64'h1_0000_0000;
	localparam int WRAP_MOD = 32'(WORD_SPAN % 64'(TABLE_SIZE));

	// request codes
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

	// result codes
	localparam logic [STAT_W-1:0] RES_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] RES_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] RES_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] RES_BAD_KEY   = 2'd3;

	// slot marks
	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic              load;
		logic              clear;
		logic              hash_step;
		logic              finalize;
		logic              rem_step;
		logic              advance;
		logic              wr_mark;
		logic [MARK_W-1:0] mark_val;
		logic              wr_key;
		logic              set_res;
		logic [STAT_W-1:0] res_code;
		logic              res_slot;
		logic              out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic              clr_last;
		logic [FUNC_W-1:0] func;
		logic              zero_key;
		logic              last_byte;
		logic              rem_last;
		logic              mark_used;
		logic              mark_empty;
		logic              key_hit;
		logic              last_probe;
		logic              out_free;
	} sts_t;

endpackage

@@ rtl/qpht_ram.sv @@
// qpht_ram: generic single write port, single read port ram with registered read
module qpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/qpht_dp.sv @@
// qpht_dp: key normalize, byte hash, probe sequence, slot stores and result register
module qpht_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  qpht_pkg::req_t req,
	input  qpht_pkg::cmd_t cmd,
	output qpht_pkg::sts_t sts,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output qpht_pkg::rsp_t rsp
);
	import qpht_pkg::*;

	localparam logic [PW-1:0] TS_X  = PW'(TABLE_SIZE);
	localparam logic [PW-1:0] WRAP_X = PW'(WRAP_MOD);
	localparam int RW = IDX_W + 5;

	function automatic logic [HASH_W-1:0] hash_byte(logic [HASH_W-1:0] h, logic [7:0] b);
		logic [HASH_W-1:0] t;
		t = h + HASH_W'(b);
		t = t + (t << 10);
		t = t ^ (t >> 6);
		return t;
	endfunction

	function automatic logic [HASH_W-1:0] hash_final(logic [HASH_W-1:0] h);
		logic [HASH_W-1:0] t;
		t = h + (h << 3);
		t = t ^ (t >> 11);
		t = t + (t << 15);
		return t;
	endfunction

	// remainder of (r*16 + nib) by the table size, r already below it
	function automatic logic [IDX_W-1:0] rem_nib(logic [IDX_W-1:0] r, logic [3:0] nib);
		logic [RW-1:0] v;
		logic [RW-1:0] m;
		logic [RW-1:0] res;
		v   = RW'({r, nib});
		res = v;
		for (int k = 1; k < 16; k++) begin
			m = RW'(k * TABLE_SIZE);
			if (v >= m) begin
				res = v - m;
			end
		end
		return res[IDX_W-1:0];
	endfunction

	logic [FUNC_W-1:0] func_q;
	logic [KEY_W-1:0]  key_q;
	logic [LEN_W-1:0]  len_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] h_q;
	logic [HASH_W-1:0] sh_q;
	logic [NIB_CW-1:0] rn_q;
	logic [HASH_W-1:0] q_q;
	logic [IDX_W-1:0]  r_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  clr_q;
	logic [STAT_W-1:0] res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [KEY_W-1:0]  norm_key;
	logic [LEN_W-1:0]  norm_len;
	logic              keep;
	logic [7:0]        kbyte;

	logic [PW-1:0]     step;
	logic [PW-1:0]     step_m;
	logic [HASH_W:0]   q_sum;
	logic [PW-1:0]     s1;
	logic [PW-1:0]     s2;
	logic [IDX_W-1:0]  r_next;

	logic [IDX_W-1:0]  raddr;
	logic [IDX_W-1:0]  mark_waddr;
	logic [MARK_W-1:0] mark_wdata;
	logic              mark_we;
	logic [MARK_W-1:0] mark_rd;
	logic [KEY_W-1:0]  key_rd;

	// keep bytes before the first zero byte, at most KEY_BYTES of them
	always_comb begin
		norm_key = '0;
		norm_len = '0;
		keep     = 1'b1;
		for (int n = 0; n < 8; n++) begin
			kbyte = req.key[8*n +: 8];
			if (n >= KEY_BYTES || kbyte == 8'd0) begin
				keep = 1'b0;
			end
			if (keep) begin
				norm_key[8*n +: 8] = kbyte;
				norm_len           = LEN_W'(n + 1);
			end
		end
	end

	// next probe: q += 2i+1 over 32 bits, r tracks q mod table size
	always_comb begin
		step   = {i_q, 1'b1};
		step_m = (step >= TS_X) ? step - TS_X : step;
		q_sum  = {1'b0, q_q} + (HASH_W + 1)'(step);
		s1     = {1'b0, r_q} + step_m;
		if (s1 >= TS_X) begin
			s1 = s1 - TS_X;
		end
		s2 = s1;
		if (q_sum[HASH_W]) begin
			s2 = (s1 < WRAP_X) ? s1 + (TS_X - WRAP_X) : s1 - WRAP_X;
		end
		r_next = s2[IDX_W-1:0];
	end

	assign raddr      = cmd.advance ? r_next : r_q;
	assign mark_we    = cmd.clear | cmd.wr_mark;
	assign mark_waddr = cmd.clear ? clr_q : r_q;
	assign mark_wdata = cmd.clear ? MARK_EMPTY : cmd.mark_val;

	qpht_ram #(.WIDTH(MARK_W), .DEPTH(TABLE_SIZE)) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.raddr (raddr),
		.rdata (mark_rd)
	);

	qpht_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SIZE)) u_key_ram (
		.clk   (clk),
		.we    (cmd.wr_key),
		.waddr (r_q),
		.wdata (key_q),
		.raddr (raddr),
		.rdata (key_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req.func;
			key_q  <= norm_key;
			len_q  <= norm_len;
			cnt_q  <= '0;
			h_q    <= '0;
		end
		if (cmd.hash_step) begin
			h_q   <= hash_byte(h_q, key_q[8*cnt_q +: 8]);
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.finalize) begin
			sh_q <= hash_final(h_q);
			q_q  <= hash_final(h_q);
			r_q  <= '0;
			rn_q <= '0;
			i_q  <= '0;
		end
		if (cmd.rem_step) begin
			r_q  <= rem_nib(r_q, sh_q[HASH_W-1 -: 4]);
			sh_q <= sh_q << 4;
			rn_q <= rn_q + NIB_CW'(1);
		end
		if (cmd.advance) begin
			r_q <= r_next;
			q_q <= q_sum[HASH_W-1:0];
			i_q <= i_q + IDX_W'(1);
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_slot_q   <= cmd.res_slot ? SLOT_W'(r_q) : '0;
		end
		if (cmd.out_load) begin
			rsp_q.status <= res_status_q;
			rsp_q.slot   <= res_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.clr_last   = (clr_q == IDX_W'(TABLE_SIZE - 1));
		sts.func       = func_q;
		sts.zero_key   = (len_q == '0);
		sts.last_byte  = ((LEN_W'(cnt_q) + LEN_W'(1)) == len_q);
		sts.rem_last   = (rn_q == NIB_CW'(NIB_N - 1));
		sts.mark_used  = (mark_rd == MARK_USED);
		sts.mark_empty = (mark_rd == MARK_EMPTY);
		sts.key_hit    = (mark_rd == MARK_USED) && (key_rd == key_q);
		sts.last_probe = (i_q == IDX_W'(TABLE_SIZE - 1));
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/qpht_ctrl.sv @@
// qpht_ctrl: request sequencer for clearing, hashing, probing and reply
module qpht_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  qpht_pkg::sts_t sts,
	output qpht_pkg::cmd_t cmd
);
	import qpht_pkg::*;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_HASH  = 8'b0000_0100,
		ST_FINAL = 8'b0000_1000,
		ST_REM   = 8'b0001_0000,
		ST_ISSUE = 8'b0010_0000,
		ST_EVAL  = 8'b0100_0000,
		ST_REPLY = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   func_ok;

	assign func_ok = (sts.func == FN_INSERT) || (sts.func == FN_SEARCH) ||
	                 (sts.func == FN_DELETE);

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_HASH;
				end
			end
			ST_HASH: begin
				if (!func_ok) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = RES_NOT_FOUND;
					state_d      = ST_REPLY;
				end else if (sts.zero_key) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = RES_BAD_KEY;
					state_d      = ST_REPLY;
				end else begin
					cmd.hash_step = 1'b1;
					if (sts.last_byte) begin
						state_d = ST_FINAL;
					end
				end
			end
			ST_FINAL: begin
				cmd.finalize = 1'b1;
				state_d      = ST_REM;
			end
			ST_REM: begin
				cmd.rem_step = 1'b1;
				if (sts.rem_last) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (sts.func == FN_INSERT) begin
					if (!sts.mark_used) begin
						cmd.wr_mark  = 1'b1;
						cmd.mark_val = MARK_USED;
						cmd.wr_key   = 1'b1;
						cmd.set_res  = 1'b1;
						cmd.res_code = RES_DONE;
						cmd.res_slot = 1'b1;
						state_d      = ST_REPLY;
					end else if (sts.last_probe) begin
						cmd.set_res  = 1'b1;
						cmd.res_code = RES_FULL;
						state_d      = ST_REPLY;
					end else begin
						cmd.advance = 1'b1;
					end
				end else begin
					if (sts.mark_empty) begin
						cmd.set_res  = 1'b1;
						cmd.res_code = RES_NOT_FOUND;
						state_d      = ST_REPLY;
					end else if (sts.key_hit) begin
						cmd.wr_mark  = (sts.func == FN_DELETE);
						cmd.mark_val = MARK_GONE;
						cmd.set_res  = 1'b1;
						cmd.res_code = RES_DONE;
						cmd.res_slot = 1'b1;
						state_d      = ST_REPLY;
					end else if (sts.last_probe) begin
						cmd.set_res  = 1'b1;
						cmd.res_code = RES_NOT_FOUND;
						state_d      = ST_REPLY;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			ST_REPLY: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/quadratic_probe_hash_table.sv @@
// quadratic_probe_hash_table: top level of the open-addressing hash table with tombstones
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req.func (2b), req.key (64b)
//   rsp      out  rsp_valid/rsp_stall   rsp.status (2b), rsp.slot (8b)
//
// one request at a time: a transfer on req is taken only while the sequencer is idle
// per request: load, hash the kept key bytes (one hash byte per cycle), finalize, reduce
//   the hash to a slot one nibble at a time, then probe slots through the registered read
//   of the slot stores until the request is settled, then reply
// a rejected request (unused func or zero key) goes from the hash state straight to reply
// after reset the mark store is swept to empty, slot by slot, with req stalled
// the result sits in an output register, so req is taken again while rsp is stalled
module quadratic_probe_hash_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  qpht_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output qpht_pkg::rsp_t rsp
);
	import qpht_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: clear sweep, hash bytes, slot reduce, probe loop, reply
	qpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: key/hash/probe registers, mark and key stores, output register
	qpht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
